// ===== hdl/pfde_pkg.sv =====
// Package with shared types and constants for the page framebuffer draw engine.
package pfde_pkg;

    localparam int unsigned MaxWidth   = 128;
    localparam int unsigned MaxHeight  = 64;
    localparam int unsigned StoreDepth = MaxWidth * MaxHeight / 8;
    localparam int unsigned AddrW      = $clog2(StoreDepth);
    localparam int unsigned QDepth     = 2;

    localparam logic [2:0] CMD_SET  = 3'd0;
    localparam logic [2:0] CMD_GET  = 3'd1;
    localparam logic [2:0] CMD_FILL = 3'd2;
    localparam logic [2:0] CMD_LINE = 3'd3;
    localparam logic [2:0] CMD_BLIT = 3'd4;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    // Work kinds after classification in the front part.
    typedef enum logic [2:0] {
        K_NONE,
        K_PIX,
        K_FILL,
        K_LINE,
        K_BLIT
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              is_get;
        logic signed [7:0] xs;
        logic signed [7:0] ys;
        logic signed [7:0] xe;
        logic signed [7:0] ye;
        logic [7:0]        color;
        logic              blit_ok;
        logic [AddrW-1:0]  blit_addr;
        logic [7:0]        sprite_byte;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRONT_DIV,
        S_FRONT_MUL,
        S_FRONT_PUSH,
        S_LINE_SETUP,
        S_LINE_STEP,
        S_PIX_ADDR,
        S_RD,
        S_WR,
        S_FILL,
        S_DONE
    } t_state;

endpackage

// ===== hdl/pfde_front.sv =====
// Front part: accepts commands and works out blit addresses before queuing.
module pfde_front
    import pfde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_xs,
    input  logic [7:0]  i_ys,
    input  logic [7:0]  i_xe,
    input  logic [7:0]  i_ye,
    input  logic [7:0]  i_color,
    input  logic [7:0]  i_sw,
    input  logic [6:0]  i_sh,
    input  logic [9:0]  i_si,
    input  logic [7:0]  i_sb,
    input  logic [7:0]  i_frame_width,
    input  logic [6:0]  i_frame_height,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    t_state r_state, n_state;
    t_job   r_job;
    logic [7:0]  r_sw;
    logic [9:0]  r_rem;
    logic [9:0]  r_page;
    logic [14:0] r_limit;
    logic signed [17:0] r_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_command == CMD_BLIT) ? S_FRONT_DIV : S_FRONT_PUSH;
                end
            end
            // Restoring division by repeated subtraction: one width a cycle.
            S_FRONT_DIV: begin
                if ({2'b0, r_sw} == 10'd0 || r_rem < {2'b0, r_sw}) begin
                    n_state = S_FRONT_MUL;
                end
            end
            S_FRONT_MUL:  n_state = S_FRONT_PUSH;
            S_FRONT_PUSH: if (!i_full) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_push  = (r_state == S_FRONT_PUSH) && !i_full;
        o_job   = r_job;
    end

    logic signed [9:0]  w_x_col;
    logic signed [10:0] w_pgrow;
    logic signed [4:0]  w_ypage;
    logic signed [17:0] w_idx;
    logic [15:0]        w_size;
    assign w_x_col = $signed({{2{r_job.xs[7]}}, r_job.xs}) + $signed({2'b0, r_rem[7:0]});
    assign w_ypage = $signed({r_job.ys[7], r_job.ys[7:4] == 4'hF && r_job.ys[7]
                     && r_job.ys[2:0] != 3'd0 ? 4'd0 : 4'd0}) + 5'sd0;
    logic signed [7:0] w_ytr;
    assign w_ytr = r_job.ys / 8'sd8;
    // Page row may go negative when the origin lies above the frame.
    assign w_pgrow = $signed({1'b0, r_page}) + 11'(w_ytr);
    assign w_idx = 18'(w_x_col) + 18'($signed({1'b0, i_frame_width}) * w_pgrow);
    assign w_size = ({8'd0, i_frame_width} * {9'd0, i_frame_height}) >> 3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_job.kind <= (i_command == CMD_SET || i_command == CMD_GET) ? K_PIX :
                              (i_command == CMD_FILL) ? K_FILL :
                              (i_command == CMD_LINE) ? K_LINE :
                              (i_command == CMD_BLIT) ? K_BLIT : K_NONE;
                r_job.is_get <= (i_command == CMD_GET);
                r_job.xs <= i_xs;
                r_job.ys <= i_ys;
                r_job.xe <= i_xe;
                r_job.ye <= i_ye;
                r_job.color <= i_color;
                r_job.sprite_byte <= i_sb;
                r_job.blit_ok <= 1'b0;
                r_job.blit_addr <= '0;
                r_sw <= i_sw;
                r_rem <= i_si;
                r_page <= '0;
                r_limit <= 15'(({7'd0, i_sw} * {8'd0, i_sh}) >> 3);
                r_idx <= '0;
            end
            S_FRONT_DIV: begin
                if (!({2'b0, r_sw} == 10'd0 || r_rem < {2'b0, r_sw})) begin
                    r_rem  <= r_rem - {2'b0, r_sw};
                    r_page <= r_page + 10'd1;
                end
            end
            S_FRONT_MUL: begin
                r_idx <= w_idx;
                r_job.blit_ok <= (r_sw != 8'd0) && ({5'd0, r_job.xs[7] ? 10'd0 : 10'd0}
                    == 15'd0) && ({5'd0, r_page * {2'd0, r_sw} + r_rem} < r_limit)
                    && (w_x_col < $signed({2'b0, i_frame_width}))
                    && (w_idx >= 0)
                    && (w_idx < $signed({2'b0, (w_size > 16'(StoreDepth)) ?
                        16'(StoreDepth) : w_size}));
                r_job.blit_addr <= w_idx[AddrW-1:0];
            end
            default: ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{w_ypage, r_idx};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_state == S_FRONT_PUSH) else $error("push outside push state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state != S_IDLE)
        else $error("accepted word not held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FRONT_DIV |-> !o_ready) else $error("ready during divide");

endmodule

// ===== hdl/pfde_queue.sv =====
// Short job queue between the front and back parts.
module pfde_queue
    import pfde_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    output logic  o_valid,
    output t_job  o_job,
    input  logic  i_pop
);

    t_job       r_mem [QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("queue count range");

endmodule

// ===== hdl/pfde_back.sv =====
// Back part: runs jobs against the frame store and produces results.
module pfde_back
    import pfde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [7:0]  i_frame_width,
    input  logic [6:0]  i_frame_height,
    output logic        o_valid,
    output logic [1:0]  o_data,
    input  logic        i_ready
);

    t_state r_state, n_state;
    t_job   r_job;
    logic [7:0]  r_mem [StoreDepth];
    logic [7:0]  r_rd;
    logic [10:0] r_clr;      // clearing pass after reset, also the fill address
    logic        r_clr_busy;
    logic [AddrW-1:0] r_addr;
    logic [2:0]  r_bit;
    logic        r_ok;
    logic        r_any;
    logic        r_pv;
    logic        r_out_v;
    logic [1:0]  r_out;
    // line walk
    logic signed [9:0] r_x, r_y, r_x1, r_dx, r_dy, r_err;
    logic              r_steep, r_ydn;
    logic signed [9:0] r_px, r_py;
    logic              r_in_line;

    logic signed [9:0] w_adx, w_ady, w_x0, w_y0, w_x1, w_y1;
    logic              w_steep;
    always_comb begin
        logic signed [9:0] a0, b0, a1, b1;
        a0 = 10'(r_job.xs); b0 = 10'(r_job.ys);
        a1 = 10'(r_job.xe); b1 = 10'(r_job.ye);
        w_adx = (a1 > a0) ? a1 - a0 : a0 - a1;
        w_ady = (b1 > b0) ? b1 - b0 : b0 - b1;
        w_steep = w_ady > w_adx;
        if (w_steep) begin
            w_x0 = b0; w_y0 = a0; w_x1 = b1; w_y1 = a1;
        end else begin
            w_x0 = a0; w_y0 = b0; w_x1 = a1; w_y1 = b1;
        end
        if (w_x0 > w_x1) begin
            {w_x0, w_x1} = {w_x1, w_x0};
            {w_y0, w_y1} = {w_y1, w_y0};
        end
    end

    // Pixel bounds and address for (r_px, r_py).
    logic [15:0] w_size;
    logic [15:0] w_idx;
    logic        w_pin;
    assign w_size = ({8'd0, i_frame_width} * {9'd0, i_frame_height}) >> 3;
    assign w_idx  = 16'(i_frame_width) * 16'(r_py[9:3]) + 16'(r_px[7:0]);
    assign w_pin  = !r_px[9] && !r_py[9] && (r_px < $signed({2'b0, i_frame_width}))
                    && (r_py < $signed({3'b0, i_frame_height}))
                    && (w_idx < ((w_size > 16'(StoreDepth)) ? 16'(StoreDepth) : w_size));

    logic signed [9:0] w_err2;
    assign w_err2 = r_err - r_dy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!r_clr_busy && i_valid && !r_out_v) begin
                    case (i_job.kind)
                        K_PIX:   n_state = S_PIX_ADDR;
                        K_FILL:  n_state = S_FILL;
                        K_LINE:  n_state = S_LINE_SETUP;
                        K_BLIT:  n_state = i_job.blit_ok ? S_RD : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LINE_SETUP: n_state = S_LINE_STEP;
            S_LINE_STEP:  n_state = (r_x > r_x1) ? S_DONE : S_PIX_ADDR;
            S_PIX_ADDR:   n_state = w_pin ? S_RD : (r_in_line ? S_LINE_STEP : S_DONE);
            S_RD:         n_state = S_WR;
            S_WR:         n_state = r_in_line ? S_LINE_STEP : S_DONE;
            S_FILL:       n_state = (r_clr == 11'(StoreDepth - 1)) ? S_DONE : S_FILL;
            S_DONE:       n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == S_IDLE) && !r_clr_busy && i_valid && !r_out_v;
        o_valid = r_out_v;
        o_data  = r_out;
    end

    logic [7:0] w_mask, w_wdata;
    assign w_mask = 8'd1 << r_bit;
    always_comb begin
        w_wdata = r_rd;
        if (r_job.kind == K_BLIT) begin
            w_wdata = r_rd | r_job.sprite_byte;
        end else if (r_job.color == 8'd1) begin
            w_wdata = r_rd | w_mask;
        end else if (r_job.color == 8'd0) begin
            w_wdata = r_rd & ~w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (r_clr_busy) begin
                if (r_clr == 11'(StoreDepth - 1)) begin
                    r_clr_busy <= 1'b0;
                    r_clr <= '0;
                end else begin
                    r_clr <= r_clr + 11'd1;
                end
            end
            if (r_state == S_FILL) begin
                r_clr <= (r_clr == 11'(StoreDepth - 1)) ? 11'd0 : r_clr + 11'd1;
            end
            if (r_state == S_DONE) begin
                r_out_v <= 1'b1;
            end
        end
        if (r_clr_busy) r_mem[r_clr[AddrW-1:0]] <= 8'd0;
        if (r_state == S_FILL) r_mem[r_clr[AddrW-1:0]] <= r_job.color;
        if (r_state == S_RD) r_rd <= r_mem[r_addr];
        if (r_state == S_WR && !r_job.is_get) r_mem[r_addr] <= w_wdata;
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_px <= 10'(i_job.xs);
                r_py <= 10'(i_job.ys);
                r_any <= 1'b0;
                r_pv <= 1'b0;
                r_in_line <= (i_job.kind == K_LINE);
                r_addr <= i_job.blit_addr;
                r_ok <= (i_job.kind == K_FILL) || (i_job.kind == K_BLIT && i_job.blit_ok);
            end
            S_LINE_SETUP: begin
                r_steep <= w_steep;
                r_x <= w_x0;
                r_y <= w_y0;
                r_x1 <= w_x1;
                r_dx <= w_x1 - w_x0;
                r_dy <= (w_y1 > w_y0) ? w_y1 - w_y0 : w_y0 - w_y1;
                r_err <= (w_x1 - w_x0) >>> 1;
                r_ydn <= !(w_y0 < w_y1);
            end
            S_LINE_STEP: begin
                r_px <= r_steep ? r_y : r_x;
                r_py <= r_steep ? r_x : r_y;
                r_x <= r_x + 10'sd1;
                if (w_err2 < 0) begin
                    r_y <= r_ydn ? r_y - 10'sd1 : r_y + 10'sd1;
                    r_err <= w_err2 + r_dx;
                end else begin
                    r_err <= w_err2;
                end
            end
            S_PIX_ADDR: begin
                r_addr <= w_idx[AddrW-1:0];
                r_bit <= r_py[2:0];
                if (w_pin) begin
                    r_ok <= 1'b1;
                    r_any <= 1'b1;
                end
            end
            S_WR: begin
                r_pv <= r_job.is_get & r_rd[r_bit];
            end
            S_DONE: begin
                r_out <= {r_in_line ? r_any : r_ok, r_pv};
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_clr_busy) else $error("job taken during clearing");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !r_out_v) else $error("result overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_WR) else $error("read not followed by write");

endmodule

// ===== hdl/page_framebuffer_draw_engine.sv =====
// Throughput: one command at a time in the back part; the front divides blit indexes
//   one sprite width a cycle while the back part runs the previous command.
// Reset: synchronous active low; registers return to 128 by 64 and a clearing pass
//   zeroes all 1024 bytes of the frame store before the back part takes the first job.
module page_framebuffer_draw_engine
    import pfde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], x_start[10:3], y_start[18:11], x_end[26:19], y_end[34:27],
    // color[42:35], sprite_width[50:43], sprite_height[57:51],
    // sprite_byte_index[67:58], sprite_byte[75:68], zeros above
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value[0], in_bounds[1], zeros above
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_frame_width;
    logic [6:0] r_frame_height;
    logic       w_push, w_full, w_qv, w_pop;
    t_job       w_fjob, w_bjob;
    logic [1:0] w_res;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= 8'd128;
            r_frame_height <= 7'd64;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) r_frame_width <= pwdata[7:0];
            else r_frame_height <= pwdata[6:0];
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_HEIGHT) prdata = {25'd0, r_frame_height};
        else prdata = {24'd0, r_frame_width};
        if (paddr[1:0] != 2'd0) prdata = 32'd0;
    end

    pfde_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_command(s_axis_tdata[2:0]), .i_xs(s_axis_tdata[10:3]),
        .i_ys(s_axis_tdata[18:11]), .i_xe(s_axis_tdata[26:19]),
        .i_ye(s_axis_tdata[34:27]), .i_color(s_axis_tdata[42:35]),
        .i_sw(s_axis_tdata[50:43]), .i_sh(s_axis_tdata[57:51]),
        .i_si(s_axis_tdata[67:58]), .i_sb(s_axis_tdata[75:68]),
        .i_frame_width(r_frame_width), .i_frame_height(r_frame_height),
        .o_push(w_push), .o_job(w_fjob), .i_full(w_full)
    );

    pfde_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_job(w_fjob), .o_full(w_full),
        .o_valid(w_qv), .o_job(w_bjob), .i_pop(w_pop)
    );

    pfde_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .i_job(w_bjob), .o_pop(w_pop),
        .i_frame_width(r_frame_width), .i_frame_height(r_frame_height),
        .o_valid(m_axis_tvalid), .o_data(w_res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, w_res};

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata[79:76], pwdata[31:8], paddr[1:0]};

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the page framebuffer draw engine: directed and random commands checked against a model.
`timescale 1ns / 100ps

class frame_scoreboard;
    logic [7:0]  store [1024];
    int unsigned fb_w;
    int unsigned fb_h;
    logic [1:0]  pending [$];
    int          errors;

    function void clear_store();
        foreach (store[k]) store[k] = 8'h00;
        fb_w = 128;
        fb_h = 64;
    endfunction

    function int active_bytes();
        int s;
        s = (fb_w * fb_h) / 8;
        if (s > 1024) s = 1024;
        return s;
    endfunction

    function int byte_of(int x, int y);
        int a;
        if (x < 0 || y < 0 || x >= int'(fb_w) || y >= int'(fb_h)) return -1;
        a = int'(fb_w) * (y / 8) + x;
        if (a >= active_bytes()) return -1;
        return a;
    endfunction

    function bit plot(int x, int y, int c);
        int a;
        a = byte_of(x, y);
        if (a < 0) return 0;
        if (c == 1) store[a][y % 8] = 1'b1;
        else if (c == 0) store[a][y % 8] = 1'b0;
        return 1;
    endfunction

    function bit walk_line(int x0, int y0, int x1, int y1, int c);
        int t, dx, dy, err, ys;
        bit steep, hit;
        hit = 0;
        steep = ((y1 > y0 ? y1 - y0 : y0 - y1) > (x1 > x0 ? x1 - x0 : x0 - x1));
        if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 > y0 ? y1 - y0 : y0 - y1;
        err = dx / 2;
        ys = (y0 < y1) ? 1 : -1;
        for (; x0 <= x1; x0++) begin
            if (steep ? plot(y0, x0, c) : plot(x0, y0, c)) hit = 1;
            err -= dy;
            if (err < 0) begin
                y0 += ys;
                err += dx;
            end
        end
        return hit;
    endfunction

    function bit blit(int x0, int y0, int w, int h, int i, logic [7:0] b);
        int a;
        if (w == 0) return 0;
        if (i >= (w * h) / 8) return 0;
        if (x0 + i % w >= int'(fb_w)) return 0;
        a = x0 + i % w + int'(fb_w) * (i / w) + (y0 / 8) * int'(fb_w);
        if (a < 0 || a >= active_bytes()) return 0;
        store[a] |= b;
        return 1;
    endfunction

    // Updates the model store and predicts the result word of one accepted command.
    function void note_command(logic [79:0] d);
        int xs, ys, a;
        logic pv, ib;
        xs = $signed(d[10:3]);
        ys = $signed(d[18:11]);
        pv = 0;
        ib = 0;
        case (d[2:0])
            pfde_pkg::CMD_SET: ib = plot(xs, ys, d[42:35]);
            pfde_pkg::CMD_GET: begin
                a = byte_of(xs, ys);
                if (a >= 0) begin
                    ib = 1;
                    pv = store[a][ys % 8];
                end
            end
            pfde_pkg::CMD_FILL: begin
                foreach (store[k]) store[k] = d[42:35];
                ib = 1;
            end
            pfde_pkg::CMD_LINE:
                ib = walk_line(xs, ys, $signed(d[26:19]), $signed(d[34:27]), d[42:35]);
            pfde_pkg::CMD_BLIT:
                ib = blit(xs, ys, d[50:43], d[57:51], d[67:58], d[75:68]);
            default: ;
        endcase
        pending.push_back({ib, pv});
    endfunction

    function void check_result(logic [7:0] r);
        logic [1:0] e;
        if (pending.size() == 0) begin
            report($sformatf("result %h with nothing pending", r));
            return;
        end
        e = pending.pop_front();
        if (r[0] !== e[0]) report($sformatf("pixel_value %b, wanted %b", r[0], e[0]));
        if (r[1] !== e[1]) report($sformatf("in_bounds %b, wanted %b", r[1], e[1]));
        if (r[7:2] !== 6'd0) report($sformatf("upper result bits %h", r[7:2]));
    endfunction

    function void report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endfunction
endclass

module tb_top;
    import pfde_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard frame_model;
    int          cmd_count;
    int          result_count;
    bit          sending_done;

    page_framebuffer_draw_engine dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    task automatic reg_write(input logic [0:0] idx, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WIDTH) frame_model.fb_w = value & 8'hFF;
        else frame_model.fb_h = value & 7'h7F;
        @(posedge i_clk);
    endtask

    // Wait for every pending result, then let a full fill or line drain out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frame_model.pending.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input int xs, input int ys,
                            input int xe, input int ye, input int col,
                            input int sw, input int sh, input int si, input int sb);
        logic [79:0] d;
        int          gap;
        d = '0;
        d[2:0] = cmd;
        d[10:3] = 8'(xs);
        d[18:11] = 8'(ys);
        d[26:19] = 8'(xe);
        d[34:27] = 8'(ye);
        d[42:35] = 8'(col);
        d[50:43] = 8'(sw);
        d[57:51] = 7'(sh);
        d[67:58] = 10'(si);
        d[75:68] = 8'(sb);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        frame_model.note_command(d);
        cmd_count++;
        // Idle gap after the word; with no gap the next word follows directly.
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_cmd();
        int r, cmd, c;
        r = $urandom_range(0, 99);
        cmd = r < 30 ? CMD_SET : r < 55 ? CMD_GET : r < 57 ? CMD_FILL :
              r < 72 ? CMD_LINE : r < 97 ? CMD_BLIT : $urandom_range(5, 7);
        c = $urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0)
            send_cmd(3'(cmd), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 127),
                     $urandom_range(0, 1023), $urandom_range(0, 255));
        else
            send_cmd(3'(cmd), $urandom_range(0, 140) - 6, $urandom_range(0, 72) - 4,
                     $urandom_range(0, 140) - 6, $urandom_range(0, 72) - 4, c,
                     $urandom_range(1, 32), 8 * $urandom_range(0, 4),
                     $urandom_range(0, 127), $urandom_range(0, 255));
    endtask

    initial begin
        frame_model = new();
        frame_model.clear_store();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sending_done = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at the reset geometry.
        send_cmd(CMD_GET, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_SET, 0, 0, 0, 0, 1, 1, 0, 0, 0);
        send_cmd(CMD_SET, 127, 63, 0, 0, 1, 1, 0, 0, 0);
        send_cmd(CMD_GET, 127, 63, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_SET, 128, 64, 0, 0, 1, 1, 0, 0, 0);
        send_cmd(CMD_GET, -1, -128, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_SET, 127, 63, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_SET, 5, 5, 0, 0, 7, 1, 0, 0, 0);
        send_cmd(CMD_LINE, -128, -128, 127, 127, 1, 1, 0, 0, 0);
        send_cmd(CMD_LINE, 3, 60, 3, 2, 1, 1, 0, 0, 0);
        send_cmd(CMD_LINE, 100, 10, 100, 10, 0, 1, 0, 0, 0);
        send_cmd(CMD_LINE, 127, -128, -128, 127, 255, 1, 0, 0, 0);
        send_cmd(CMD_GET, 64, 64, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_BLIT, -3, -9, 0, 0, 0, 8, 16, 2, 8'hA5);
        send_cmd(CMD_BLIT, 120, 0, 0, 0, 0, 16, 16, 9, 8'hFF);
        send_cmd(CMD_BLIT, 0, 0, 0, 0, 0, 0, 64, 0, 8'hFF);
        send_cmd(CMD_BLIT, 0, 56, 0, 0, 0, 128, 64, 1023, 8'h81);
        send_cmd(CMD_BLIT, 0, 0, 0, 0, 0, 255, 127, 1023, 8'h3C);
        send_cmd(3'd7, 1, 1, 0, 0, 1, 1, 0, 0, 0);
        send_cmd(CMD_FILL, 0, 0, 0, 0, 8'hFF, 1, 0, 0, 0);
        send_cmd(CMD_GET, 9, 9, 0, 0, 0, 1, 0, 0, 0);
        send_cmd(CMD_FILL, 0, 0, 0, 0, 8'h00, 1, 0, 0, 0);

        // Random phases across several geometries, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin reg_write(REG_WIDTH, 8); reg_write(REG_HEIGHT, 8); end
                1: begin reg_write(REG_WIDTH, 128); reg_write(REG_HEIGHT, 64); end
                2: begin reg_write(REG_WIDTH, 37); reg_write(REG_HEIGHT, 24); end
                3: begin reg_write(REG_WIDTH, 255); reg_write(REG_HEIGHT, 127); end
                4: begin reg_write(REG_WIDTH, 0); reg_write(REG_HEIGHT, 0); end
                default: begin
                    reg_write(REG_WIDTH, $urandom_range(8, 128));
                    reg_write(REG_HEIGHT, 8 * $urandom_range(1, 8));
                end
            endcase
            repeat (150) random_cmd();
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Result side: random stalls with occasional runs of steady acceptance.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(0, 4);
            m_axis_tready <= (stall == 0);
            @(posedge i_clk);
            if (stall != 0) begin
                repeat (stall - 1) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            frame_model.check_result(m_axis_tdata);
            result_count++;
        end
    end

    initial begin
        wait (sending_done);
        while (frame_model.pending.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        $display("Ran %0d commands over six geometries, %0d results checked.",
                 cmd_count, result_count);
        if (frame_model.errors == 0 && frame_model.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
